FILE: hw/rtl/bsr_pkg.sv
package bsr_pkg;

   // Field widths of one request and one response.
   localparam int DATA_W  = 8;
   localparam int COUNT_W = 8;
   localparam int OP_W    = 3;

   // Request codes.
   typedef enum logic [OP_W-1:0] {
      OP_PUSH     = 3'd0,
      OP_POP      = 3'd1,
      OP_PEEK     = 3'd2,
      OP_DUP      = 3'd3,
      OP_ROT_UP   = 3'd4,
      OP_ROT_DOWN = 3'd5
   } op_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_COUNT = 2'd3
   } status_type;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_COPY  = 6'b000010,
      S_KEEP  = 6'b000100,
      S_SHIFT = 6'b001000,
      S_LAST  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

endpackage

FILE: hw/rtl/bsr_ram.sv
module bsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/byte_stack_with_rotate.sv
// Byte stack with push, pop, peek, duplicate and rotate requests.
// A request is transferred at a rising clock edge where start is high and
// busy is low; req_type, req_value and req_count are sampled at that edge.
// Every request produces exactly one response: rsp_valid is high for one
// cycle with rsp_data and rsp_status, and the response is taken at the
// edge that ends that cycle. The receiver cannot stall the block.
// Push, pop, peek, failed requests and rotates that do nothing answer in the
// next cycle; a duplicate passes through the copy state first, and a rotate
// walks through the keep state, the shift state per further entry, then last.
// busy is low during the response cycle, so a new request may follow at
// once: push, pop and peek run at one per cycle, while a duplicate or a
// rotate holds busy high until its response. The sequencer moves entries
// through the single storage RAM, one entry per cycle, through its one
// read port and one write port.
// Synchronous reset empties the stack and returns the sequencer to idle;
// no clearing pass is needed, since only entries below the level are read.
module byte_stack_with_rotate #(
   parameter int DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bsr_pkg::OP_W-1:0]      req_type,
   input  logic [bsr_pkg::DATA_W-1:0]    req_value,
   input  logic [bsr_pkg::COUNT_W-1:0]   req_count,
   output logic                          rsp_valid,
   output logic [bsr_pkg::DATA_W-1:0]    rsp_data,
   output logic [1:0]                    rsp_status
);

   import bsr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;

   state_type        state_ff, state_in;
   logic [LW-1:0]    level_ff, level_in;
   logic [LW-1:0]    moves_ff, moves_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic             dir_up_ff, dir_up_in;
   logic [DATA_W-1:0] keep_ff, keep_in;
   logic             data_sel_ff, data_sel_in;
   status_type       status_ff, status_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic              can_accept;
   logic              accept;
   logic              empty;
   logic              full;
   logic [CW-1:0]     cnt_ext;
   logic [CW-1:0]     lvl_ext;
   logic [LW-1:0]     n_lw;
   logic [LW-1:0]     lvl_m1;
   logic [LW-1:0]     lo_lvl;
   logic [AW-1:0]     top_addr;
   logic [AW-1:0]     lo_addr;
   logic [AW-1:0]     step_ptr;
   logic [AW-1:0]     step_wr;

   // Storage for the stack entries.
   bsr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Level flags and the addresses a request needs.
   assign empty    = (level_ff == '0);
   assign full     = (level_ff == LW'(DEPTH));
   assign cnt_ext  = CW'(req_count);
   assign lvl_ext  = CW'(level_ff);
   assign n_lw     = cnt_ext[LW-1:0];
   assign lvl_m1   = level_ff - LW'(1);
   assign lo_lvl   = level_ff - n_lw;
   assign top_addr = lvl_m1[AW-1:0];
   assign lo_addr  = lo_lvl[AW-1:0];

   // One step along a rotate, toward the bottom for rotate up.
   assign step_ptr = dir_up_ff ? (rd_ptr_ff - AW'(1)) : (rd_ptr_ff + AW'(1));
   assign step_wr  = dir_up_ff ? (wr_ptr_ff - AW'(1)) : (wr_ptr_ff + AW'(1));

   // A new request may come in while idle or while a response is shown.
   assign can_accept = (state_ff == S_IDLE) || (state_ff == S_DONE);
   assign accept     = start && can_accept;
   assign busy       = !can_accept;

   // Sequencer: request decode, entry copy and the rotate walk.
   always_comb begin
      state_in    = state_ff;
      level_in    = level_ff;
      moves_in    = moves_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      dir_up_in   = dir_up_ff;
      keep_in     = keep_ff;
      data_sel_in = data_sel_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_ptr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_ptr_ff;

      unique case (state_ff)
         S_IDLE, S_DONE: begin
            state_in = S_IDLE;
            if (accept) begin
               state_in    = S_DONE;
               data_sel_in = 1'b0;
               status_in   = ST_OK;
               unique case (op_type'(req_type))
                  OP_PUSH: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = level_ff[AW-1:0];
                        ram_wr_data = req_value;
                        level_in    = level_ff + LW'(1);
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = top_addr;
                        data_sel_in = 1'b1;
                        if (op_type'(req_type) == OP_POP) begin
                           level_in = lvl_m1;
                        end
                     end
                  end
                  OP_DUP: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = top_addr;
                        state_in    = S_COPY;
                     end
                  end
                  OP_ROT_UP, OP_ROT_DOWN: begin
                     if (cnt_ext == '0 || empty) begin
                        status_in = ST_OK;
                     end else if (cnt_ext > lvl_ext) begin
                        status_in = ST_COUNT;
                     end else begin
                        dir_up_in = (op_type'(req_type) == OP_ROT_UP);
                        moves_in  = n_lw - LW'(1);
                        ram_rd_en = 1'b1;
                        state_in  = S_KEEP;
                        if (op_type'(req_type) == OP_ROT_UP) begin
                           ram_rd_addr = top_addr;
                           wr_ptr_in   = top_addr;
                           rd_ptr_in   = top_addr - AW'(1);
                        end else begin
                           ram_rd_addr = lo_addr;
                           wr_ptr_in   = lo_addr;
                           rd_ptr_in   = lo_addr + AW'(1);
                        end
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_COPY: begin
            // The top entry has been read; write its copy above it.
            ram_wr_en   = 1'b1;
            ram_wr_addr = level_ff[AW-1:0];
            level_in    = level_ff + LW'(1);
            state_in    = S_DONE;
         end
         S_KEEP: begin
            // Hold the entry that wraps around and start the walk.
            keep_in = ram_rd_data;
            if (moves_ff != '0) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = step_ptr;
               state_in  = S_SHIFT;
            end else begin
               state_in = S_LAST;
            end
         end
         S_SHIFT: begin
            // Move one entry per cycle while reading the next one.
            ram_wr_en = 1'b1;
            wr_ptr_in = step_wr;
            moves_in  = moves_ff - LW'(1);
            if (moves_ff > LW'(1)) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = step_ptr;
            end else begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = keep_ff;
            state_in    = S_DONE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      moves_ff    <= moves_in;
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      dir_up_ff   <= dir_up_in;
      keep_ff     <= keep_in;
      data_sel_ff <= data_sel_in;
      status_ff   <= status_in;
   end

   // Response transfer.
   assign rsp_valid  = (state_ff == S_DONE);
   assign rsp_data   = data_sel_ff ? ram_rd_data : '0;
   assign rsp_status = status_ff;

`ifndef SYNTH
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff != S_IDLE)
      else $error("accepted request did not start the sequencer");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(DEPTH))
      else $error("stack level beyond depth");

   a_shift_has_moves: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> moves_ff != '0)
      else $error("rotate walk ran past its count");

   a_copy_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |=> level_ff == LW'($past(level_ff) + LW'(1)))
      else $error("duplicate did not raise the level by one");
`endif

endmodule

FILE: sim/stack_checker.sv
`timescale 1ns / 1ps

// Watches the request and response channels of the byte stack, keeps its own
// copy of the stack contents, and checks every response against the
// prediction for the oldest outstanding request.
module stack_checker
   import bsr_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [OP_W-1:0]     req_type,
   input  logic [DATA_W-1:0]   req_value,
   input  logic [COUNT_W-1:0]  req_count,
   input  logic                rsp_valid,
   input  logic [DATA_W-1:0]   rsp_data,
   input  logic [1:0]          rsp_status,
   output int                  error_count,
   output int                  outstanding
);

   typedef struct packed {
      logic [DATA_W-1:0] data;
      status_type        status;
   } stack_response;

   // Shadow copy of the stack storage and its fill level.
   logic [DATA_W-1:0] shadow_mem [0:DEPTH-1];
   int                shadow_level;

   // Responses still owed by the block, oldest first.
   stack_response pending_rsp [$];

   int mismatches = 0;

   assign error_count = mismatches;

   // Count a failure and describe the first few of them.
   function automatic void report_failure(string what, stack_response want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected data %02h status %0d, got data %02h status %0d",
                  $realtime, what, want.data, want.status, rsp_data, rsp_status);
      end
   endfunction

   // Apply one request to the shadow stack and return the response it earns.
   function automatic stack_response apply_request(logic [OP_W-1:0] kind,
                                                   logic [DATA_W-1:0] val,
                                                   logic [COUNT_W-1:0] cnt);
      stack_response     r;
      int                lo;
      int                top;
      logic [DATA_W-1:0] keep;
      r.data   = '0;
      r.status = ST_OK;
      top      = shadow_level - 1;
      case (kind)
         OP_PUSH: begin
            if (shadow_level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_mem[shadow_level] = val;
               shadow_level++;
            end
         end
         OP_POP: begin
            if (shadow_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_level--;
               r.data = shadow_mem[shadow_level];
            end
         end
         OP_PEEK: begin
            if (shadow_level == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = shadow_mem[top];
            end
         end
         OP_DUP: begin
            // A copy of the top is pushed whatever its value.
            if (shadow_level == 0) begin
               r.status = ST_EMPTY;
            end else if (shadow_level >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_mem[shadow_level] = shadow_mem[top];
               shadow_level++;
            end
         end
         OP_ROT_UP, OP_ROT_DOWN: begin
            // A zero count or an empty stack leaves everything as it is.
            if (cnt != 0 && shadow_level != 0) begin
               if (int'(cnt) > shadow_level) begin
                  r.status = ST_COUNT;
               end else if (kind == OP_ROT_UP) begin
                  lo = shadow_level - int'(cnt);
                  keep = shadow_mem[top];
                  for (int t = top; t > lo; t--) begin
                     shadow_mem[t] = shadow_mem[t-1];
                  end
                  shadow_mem[lo] = keep;
               end else begin
                  lo = shadow_level - int'(cnt);
                  keep = shadow_mem[lo];
                  for (int i = lo; i < top; i++) begin
                     shadow_mem[i] = shadow_mem[i+1];
                  end
                  shadow_mem[top] = keep;
               end
            end
         end
         default: begin
            // Unused request codes are answered with ok and no data.
         end
      endcase
      return r;
   endfunction

   // The response is matched before a request in the same cycle is predicted,
   // since a request can be transferred in the cycle of the previous response.
   always @(posedge clock) begin
      stack_response oldest;
      if (reset) begin
         pending_rsp.delete();
         shadow_level = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pending_rsp.size() == 0) begin
               oldest = '0;
               report_failure("response with no request outstanding", oldest);
            end else begin
               oldest = pending_rsp.pop_front();
               if (rsp_data !== oldest.data) begin
                  report_failure("data mismatch", oldest);
               end else if (rsp_status !== oldest.status) begin
                  report_failure("status mismatch", oldest);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            pending_rsp.push_back(apply_request(req_type, req_value, req_count));
         end
      end
      outstanding <= pending_rsp.size();
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bsr_pkg::*;

   localparam int STACK_DEPTH  = 128;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_ITEMS  = 163;

   // Request codes the block answers without doing anything.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   // Request mixes for the random phases.
   typedef enum int {
      MIX_FILL,
      MIX_ROTATE,
      MIX_BALANCED,
      MIX_DRAIN
   } request_mix;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_type = '0;
   logic [DATA_W-1:0]   req_value = '0;
   logic [COUNT_W-1:0]  req_count = '0;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_data;
   logic [1:0]          rsp_status;
   int                  error_count;
   int                  outstanding;

   // Rough fill level, only used to aim rotate counts.
   int  approx_level = 0;
   bit  idle_enable = 1'b1;

   always #5 clock = ~clock;

   byte_stack_with_rotate #(
      .DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_type   (req_type),
      .req_value  (req_value),
      .req_count  (req_count),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status)
   );

   stack_checker #(
      .DEPTH(STACK_DEPTH)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_value   (req_value),
      .req_count   (req_count),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_status  (rsp_status),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // Offer one request and hold it until its transfer.
   task automatic send_request(logic [OP_W-1:0] kind, logic [DATA_W-1:0] val,
                               logic [COUNT_W-1:0] cnt);
      while (idle_enable && $urandom_range(99) < 6) begin
         start     <= 1'b0;
         req_type  <= $urandom_range(7);
         req_value <= $urandom_range(255);
         req_count <= $urandom_range(255);
         @(posedge clock);
      end
      start     <= 1'b1;
      req_type  <= kind;
      req_value <= val;
      req_count <= cnt;
      do @(posedge clock); while (busy !== 1'b0);
      case (kind)
         OP_PUSH: if (approx_level < STACK_DEPTH) approx_level++;
         OP_DUP:  if (approx_level > 0 && approx_level < STACK_DEPTH) approx_level++;
         OP_POP:  if (approx_level > 0) approx_level--;
         default: ;
      endcase
   endtask

   // Pick a request code with weights that depend on the phase mix.
   function automatic logic [OP_W-1:0] pick_request(request_mix mix);
      int roll;
      int lim_push, lim_dup, lim_pop, lim_peek, lim_up, lim_down;
      roll = $urandom_range(99);
      case (mix)
         MIX_FILL:     {lim_push, lim_dup, lim_pop, lim_peek, lim_up, lim_down} =
                       {32'd80, 32'd88, 32'd91, 32'd94, 32'd96, 32'd98};
         MIX_ROTATE:   {lim_push, lim_dup, lim_pop, lim_peek, lim_up, lim_down} =
                       {32'd8, 32'd12, 32'd16, 32'd24, 32'd61, 32'd98};
         MIX_BALANCED: {lim_push, lim_dup, lim_pop, lim_peek, lim_up, lim_down} =
                       {32'd30, 32'd40, 32'd65, 32'd75, 32'd86, 32'd97};
         default:      {lim_push, lim_dup, lim_pop, lim_peek, lim_up, lim_down} =
                       {32'd10, 32'd13, 32'd78, 32'd88, 32'd93, 32'd98};
      endcase
      if (roll < lim_push) return OP_PUSH;
      if (roll < lim_dup)  return OP_DUP;
      if (roll < lim_pop)  return OP_POP;
      if (roll < lim_peek) return OP_PEEK;
      if (roll < lim_up)   return OP_ROT_UP;
      if (roll < lim_down) return OP_ROT_DOWN;
      return (roll[0]) ? OP_SPARE_HI : OP_SPARE_LO;
   endfunction

   // Mostly counts that fit the stack, a few zero, too large or the maximum.
   function automatic logic [COUNT_W-1:0] pick_count(int lvl);
      int roll;
      int fit;
      roll = $urandom_range(99);
      fit  = (lvl > 0) ? lvl : 1;
      if (roll < 8)  return '0;
      if (roll < 16) return COUNT_W'(STACK_DEPTH);
      if (roll < 26) return COUNT_W'((lvl < STACK_DEPTH) ?
                                     $urandom_range(STACK_DEPTH, lvl + 1) : STACK_DEPTH);
      if (roll < 60) return COUNT_W'($urandom_range((fit < 4) ? fit : 4, 1));
      return COUNT_W'($urandom_range(fit, 1));
   endfunction

   // Boundary values come up more often than their share.
   function automatic logic [DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return DATA_W'($urandom_range(255));
   endfunction

   // Stop the sender until the block owes nothing.
   task automatic wait_until_settled();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Timeout guard.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      request_mix mix;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Requests on the empty stack.
      send_request(OP_POP, 8'h3C, 8'd0);
      send_request(OP_PEEK, 8'h00, 8'd1);
      send_request(OP_DUP, 8'hFF, 8'd2);
      send_request(OP_ROT_UP, 8'h11, 8'd5);
      send_request(OP_ROT_DOWN, 8'h22, 8'd0);

      // Duplicate of a top entry that holds all ones.
      send_request(OP_PUSH, 8'h00, 8'd0);
      send_request(OP_PUSH, 8'hFF, 8'd255);
      send_request(OP_DUP, 8'h00, 8'd0);
      send_request(OP_PEEK, 8'h00, 8'd0);
      send_request(OP_PUSH, 8'hA5, 8'd0);
      send_request(OP_PUSH, 8'h5A, 8'd0);

      // Rotates over the whole stack and part of it.
      send_request(OP_ROT_UP, 8'h00, 8'd5);
      send_request(OP_PEEK, 8'h00, 8'd0);
      send_request(OP_ROT_DOWN, 8'h00, 8'd5);
      send_request(OP_ROT_DOWN, 8'h00, 8'd3);
      send_request(OP_ROT_UP, 8'h00, 8'd2);

      // Zero count, and counts above the level.
      send_request(OP_ROT_UP, 8'h00, 8'd0);
      send_request(OP_ROT_DOWN, 8'h00, 8'd6);
      send_request(OP_ROT_UP, 8'h00, 8'd128);

      // Unused codes.
      send_request(OP_SPARE_LO, 8'hFF, 8'd128);
      send_request(OP_SPARE_HI, 8'h81, 8'd1);

      send_request(OP_POP, 8'h00, 8'd0);
      send_request(OP_POP, 8'h00, 8'd0);
      send_request(OP_POP, 8'h00, 8'd0);

      // Random phases cycle through the fill, rotate, balanced and drain mixes.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         mix = request_mix'(phase % 4);
         idle_enable = (phase != 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(pick_request(mix), pick_value(), pick_count(approx_level));
         end
         if (phase == 4) begin
            wait_until_settled();
         end
      end

      wait_until_settled();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
